// ----- hdl/b32e_pkg.sv -----
`timescale 1ns / 1ps
// Package for the base32 stream encoder: codes, widths, result types and the alphabet.
// Depends on nothing; every other file of the encoder uses it.
package b32e_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int MAX_RESULTS       = 9;
    localparam int COUNT_W           = 4;

    // Reciprocal of five in 16 fractional bits, exact for dividends below 16384.
    localparam logic [14:0] RECIP_FIVE = 15'd13108;

    localparam logic [6:0] CHAR_PAD = 7'h3D;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_SMALL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [6:0] character;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        result_t [MAX_RESULTS-1:0]     list;
    } burst_t;

    function automatic logic [6:0] symbol_char(input logic [4:0] v);
        logic [6:0] c;
        if (v < 5'd26)
        begin
            c = 7'h41 + {2'b00, v};
        end
        else
        begin
            c = 7'h32 + {2'b00, v} - 7'd26;
        end
        return c;
    endfunction

endpackage

// ----- hdl/base32_stream_encoder_top.sv -----
`timescale 1ns / 1ps
// Base32 stream encoder with '=' padding, top level: b32e_core and b32e_emit.
// Uses b32e_pkg.
//
// A start transfer checks the message against the buffer size and opens it if it fits
// and is not empty, else yields a size error or end marker. Each data transfer of an
// open message yields the characters it completes; the last byte also yields any
// partial character and padding, and an end marker. Results leave one per cycle, while
// out_ready is high, from an output register fed by the burst register. An input
// transfer can be taken every cycle while each item yields at most one result and the
// output does not stall; a longer burst holds the input till its last result is sent.
module base32_stream_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [12:0] message_length,
    input  logic [13:0] buffer_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  character,
    output logic [1:0]  kind,
    output logic        last
);

    b32e_pkg::burst_t burst;
    logic             burst_free;
    logic             take;

    assign in_ready = burst_free;
    assign take     = in_valid && burst_free;

    b32e_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .op             (op),
        .message_length (message_length),
        .buffer_length  (buffer_length),
        .data_byte      (data_byte),
        .burst          (burst)
    );

    b32e_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .burst      (burst),
        .burst_free (burst_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .kind       (kind),
        .last       (last)
    );

endmodule

// ----- hdl/b32e_core.sv -----
`timescale 1ns / 1ps
// Message state and result composition for the base32 stream encoder.
// Uses b32e_pkg; feeds a complete burst of results to b32e_emit.
module b32e_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic                      op,
    input  logic [12:0]               message_length,
    input  logic [13:0]               buffer_length,
    input  logic [7:0]                data_byte,
    output b32e_pkg::burst_t          burst
);

    logic        message_open_reg, message_open_next;
    logic [12:0] bytes_left_reg, bytes_left_next;
    logic [2:0]  group_position_reg, group_position_next;
    logic [3:0]  carry_bits_reg, carry_bits_next;

    logic [13:0] groups_in;
    logic [28:0] groups_prod;
    logic [15:0] need;
    logic        too_small;

    always_comb
    begin
        groups_in   = {1'b0, message_length} + 14'd4;
        groups_prod = {15'b0, groups_in} * {14'b0, b32e_pkg::RECIP_FIVE};
        need        = {groups_prod[28:16], 3'b000};
        too_small   = (buffer_length == '0)
                   || ({3'b000, message_length} > 16'(b32e_pkg::MAX_MESSAGE_BYTES))
                   || (need >= {2'b00, buffer_length});
    end

    always_comb
    begin
        logic [4:0] sym0;
        logic [4:0] sym1;
        logic [1:0] n_sym;
        logic [4:0] partial;
        logic [2:0] pads;
        logic       has_partial;
        logic       final_byte;
        logic [3:0] j;

        sym0        = '0;
        sym1        = '0;
        n_sym       = '0;
        partial     = '0;
        pads        = '0;
        has_partial = 1'b0;
        final_byte  = 1'b0;
        j           = '0;

        message_open_next   = message_open_reg;
        bytes_left_next     = bytes_left_reg;
        group_position_next = group_position_reg;
        carry_bits_next     = carry_bits_reg;
        burst.count         = '0;
        burst.list          = '0;

        if (op == b32e_pkg::OP_START)
        begin
            message_open_next   = 1'b0;
            bytes_left_next     = '0;
            group_position_next = '0;
            carry_bits_next     = '0;
            burst.count         = 4'd1;
            if (too_small)
            begin
                burst.list[0].kind = b32e_pkg::KIND_SMALL;
            end
            else if (message_length == '0)
            begin
                burst.list[0].kind = b32e_pkg::KIND_END;
            end
            else
            begin
                burst.count       = '0;
                message_open_next = 1'b1;
                bytes_left_next   = message_length;
            end
        end
        else if (message_open_reg)
        begin
            case (group_position_reg)
                3'd0:
                begin
                    sym0            = data_byte[7:3];
                    n_sym           = 2'd1;
                    carry_bits_next = {1'b0, data_byte[2:0]};
                    partial         = {data_byte[2:0], 2'b00};
                    pads            = 3'd6;
                    has_partial     = 1'b1;
                end
                3'd1:
                begin
                    sym0            = {carry_bits_reg[2:0], data_byte[7:6]};
                    sym1            = data_byte[5:1];
                    n_sym           = 2'd2;
                    carry_bits_next = {3'b000, data_byte[0]};
                    partial         = {data_byte[0], 4'b0000};
                    pads            = 3'd4;
                    has_partial     = 1'b1;
                end
                3'd2:
                begin
                    sym0            = {carry_bits_reg[0], data_byte[7:4]};
                    n_sym           = 2'd1;
                    carry_bits_next = data_byte[3:0];
                    partial         = {data_byte[3:0], 1'b0};
                    pads            = 3'd3;
                    has_partial     = 1'b1;
                end
                3'd3:
                begin
                    sym0            = {carry_bits_reg, data_byte[7]};
                    sym1            = data_byte[6:2];
                    n_sym           = 2'd2;
                    carry_bits_next = {2'b00, data_byte[1:0]};
                    partial         = {data_byte[1:0], 3'b000};
                    pads            = 3'd1;
                    has_partial     = 1'b1;
                end
                default:
                begin
                    sym0            = {carry_bits_reg[1:0], data_byte[7:5]};
                    sym1            = data_byte[4:0];
                    n_sym           = 2'd2;
                    carry_bits_next = '0;
                end
            endcase

            group_position_next = (group_position_reg >= 3'd4) ? 3'd0
                                                                : group_position_reg + 3'd1;
            bytes_left_next     = bytes_left_reg - 13'd1;
            final_byte          = (bytes_left_reg == 13'd1);

            burst.count = {2'b00, n_sym};
            if (final_byte)
            begin
                burst.count = {2'b00, n_sym} + 4'd1
                            + (has_partial ? {1'b0, pads} + 4'd1 : 4'd0);
                message_open_next   = 1'b0;
                group_position_next = '0;
                carry_bits_next     = '0;
            end

            for (int i = 0; i < b32e_pkg::MAX_RESULTS; i++)
            begin
                j = 4'(i) - {2'b00, n_sym};
                if (4'(i) < burst.count)
                begin
                    if (4'(i) < {2'b00, n_sym})
                    begin
                        burst.list[i].character = b32e_pkg::symbol_char((i == 0) ? sym0 : sym1);
                        burst.list[i].kind      = b32e_pkg::KIND_CHAR;
                    end
                    else if (has_partial && j == 4'd0)
                    begin
                        burst.list[i].character = b32e_pkg::symbol_char(partial);
                        burst.list[i].kind      = b32e_pkg::KIND_CHAR;
                    end
                    else if (has_partial && j <= {1'b0, pads})
                    begin
                        burst.list[i].character = b32e_pkg::CHAR_PAD;
                        burst.list[i].kind      = b32e_pkg::KIND_CHAR;
                    end
                    else
                    begin
                        burst.list[i].kind = b32e_pkg::KIND_END;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_open_reg   <= 1'b0;
            bytes_left_reg     <= '0;
            group_position_reg <= '0;
            carry_bits_reg     <= '0;
        end
        else if (take)
        begin
            message_open_reg   <= message_open_next;
            bytes_left_reg     <= bytes_left_next;
            group_position_reg <= group_position_next;
            carry_bits_reg     <= carry_bits_next;
        end
    end

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        message_open_reg |-> (bytes_left_reg != '0))
        else $error("open message with no bytes left");

    a_closed_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !message_open_reg |-> (group_position_reg == '0 && carry_bits_reg == '0))
        else $error("closed message left group state behind");

endmodule

// ----- hdl/b32e_emit.sv -----
`timescale 1ns / 1ps
// Burst holding register and output register of the base32 stream encoder.
// Uses b32e_pkg; sends one result per transfer from the burst built by b32e_core.
module b32e_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  b32e_pkg::burst_t     burst,
    output logic                 burst_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           character,
    output logic [1:0]           kind,
    output logic                 last
);

    b32e_pkg::result_t [b32e_pkg::MAX_RESULTS-1:0] list_reg, list_next;
    logic [b32e_pkg::COUNT_W-1:0] count_reg, count_next;
    logic               valid_reg;
    b32e_pkg::result_t  result_reg;
    logic               last_reg;
    logic               out_load;

    assign out_load   = (count_reg != '0) && (!valid_reg || out_ready);
    assign burst_free = (count_reg == '0) || (count_reg == 4'd1 && out_load);

    always_comb
    begin
        list_next  = list_reg;
        count_next = count_reg;
        if (take)
        begin
            list_next  = burst.list;
            count_next = burst.count;
        end
        else if (out_load)
        begin
            for (int i = 0; i < b32e_pkg::MAX_RESULTS - 1; i++)
            begin
                list_next[i] = list_reg[i + 1];
            end
            list_next[b32e_pkg::MAX_RESULTS-1] = '0;
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
        if (out_load)
        begin
            result_reg <= list_reg[0];
            last_reg   <= (count_reg == 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign character = result_reg.character;
    assign kind      = result_reg.kind;
    assign last      = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'(b32e_pkg::MAX_RESULTS))
        else $error("burst count beyond the largest burst");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (count_reg == '0 || (count_reg == 4'd1 && out_load)))
        else $error("burst loaded over pending results");

    a_pending_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && !valid_reg) |=> valid_reg)
        else $error("pending result not presented");

endmodule

// ----- bench/b32e_stream_checker.sv -----
`timescale 1ns / 1ps
// Checker for the base32 stream encoder: predicts the characters, end markers and size
// errors from each input transfer and compares every output transfer in order.
// Uses b32e_pkg; instantiated beside the encoder by base32_stream_encoder_top_tb.
module b32e_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        op,
    input  logic [12:0] message_length,
    input  logic [13:0] buffer_length,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  character,
    input  logic [1:0]  kind,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);

    localparam logic [8*32-1:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [6:0]      character;
        b32e_pkg::kind_t kind;
        logic            last;
    } encoded_t;

    encoded_t    awaited_text[$];
    encoded_t    burst[$];
    logic        msg_open = 1'b0;
    logic [12:0] bytes_due = '0;
    logic [2:0]  slot = '0;
    logic [3:0]  carry = '0;

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic logic [6:0] base32_symbol(input logic [4:0] v);
        return ALPHABET[8 * (31 - int'(v)) +: 7];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_result(input logic [6:0] ch, input b32e_pkg::kind_t k);
        encoded_t r;
        r.character = ch;
        r.kind = k;
        r.last = 1'b0;
        burst.push_back(r);
    endtask

    task automatic predict_encoding(input logic op_in, input logic [12:0] len,
                                    input logic [13:0] blen, input logic [7:0] b);
        int         need;
        int         pads;
        int         i;
        logic       has_part;
        logic [4:0] part;
        burst.delete();
        pads = 0;
        has_part = 1'b0;
        part = '0;
        if (op_in == b32e_pkg::OP_START)
        begin
            need = ((int'(len) + 4) / 5) * 8;
            msg_open = 1'b0;
            bytes_due = '0;
            slot = '0;
            carry = '0;
            if (blen == 0 || int'(len) > b32e_pkg::MAX_MESSAGE_BYTES || need > int'(blen) - 1)
                add_result(7'd0, b32e_pkg::KIND_SMALL);
            else if (len == 0)
                add_result(7'd0, b32e_pkg::KIND_END);
            else
            begin
                msg_open = 1'b1;
                bytes_due = len;
            end
        end
        else if (msg_open)
        begin
            case (slot)
                3'd0:
                begin
                    add_result(base32_symbol(b[7:3]), b32e_pkg::KIND_CHAR);
                    carry = {1'b0, b[2:0]};
                    part = {b[2:0], 2'b00};
                    pads = 6;
                    has_part = 1'b1;
                end
                3'd1:
                begin
                    add_result(base32_symbol({carry[2:0], b[7:6]}), b32e_pkg::KIND_CHAR);
                    add_result(base32_symbol(b[5:1]), b32e_pkg::KIND_CHAR);
                    carry = {3'b000, b[0]};
                    part = {b[0], 4'b0000};
                    pads = 4;
                    has_part = 1'b1;
                end
                3'd2:
                begin
                    add_result(base32_symbol({carry[0], b[7:4]}), b32e_pkg::KIND_CHAR);
                    carry = b[3:0];
                    part = {b[3:0], 1'b0};
                    pads = 3;
                    has_part = 1'b1;
                end
                3'd3:
                begin
                    add_result(base32_symbol({carry[3:0], b[7]}), b32e_pkg::KIND_CHAR);
                    add_result(base32_symbol(b[6:2]), b32e_pkg::KIND_CHAR);
                    carry = {2'b00, b[1:0]};
                    part = {b[1:0], 3'b000};
                    pads = 1;
                    has_part = 1'b1;
                end
                default:
                begin
                    add_result(base32_symbol({carry[1:0], b[7:5]}), b32e_pkg::KIND_CHAR);
                    add_result(base32_symbol(b[4:0]), b32e_pkg::KIND_CHAR);
                    carry = '0;
                end
            endcase
            slot = (slot >= 3'd4) ? 3'd0 : slot + 3'd1;
            bytes_due = bytes_due - 13'd1;
            if (bytes_due == 0)
            begin
                if (has_part)
                begin
                    add_result(base32_symbol(part), b32e_pkg::KIND_CHAR);
                    for (i = 0; i < pads; i++)
                        add_result(b32e_pkg::CHAR_PAD, b32e_pkg::KIND_CHAR);
                end
                add_result(7'd0, b32e_pkg::KIND_END);
                msg_open = 1'b0;
                slot = '0;
                carry = '0;
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            awaited_text.push_back(burst[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        encoded_t want;
        if (!rst_n)
        begin
            awaited_text.delete();
            msg_open = 1'b0;
            bytes_due = '0;
            slot = '0;
            carry = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_text.size() == 0)
                    report_mismatch($sformatf("unexpected result: char %h kind %0d last %0d",
                                              character, kind, last));
                else
                begin
                    want = awaited_text.pop_front();
                    if (character !== want.character)
                        report_mismatch($sformatf("character %h, expected %h",
                                                  character, want.character));
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                end
            end
            if (in_valid && in_ready)
                predict_encoding(op, message_length, buffer_length, data_byte);
        end
        outstanding = awaited_text.size();
    end

endmodule

// ----- bench/base32_stream_encoder_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the base32 stream encoder: clock, reset, stimulus, output stalls
// and the verdict. Uses b32e_pkg, base32_stream_encoder_top and b32e_stream_checker.
module base32_stream_encoder_top_tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = b32e_pkg::OP_START;
    logic [12:0] message_length = '0;
    logic [13:0] buffer_length = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  character;
    logic [1:0]  kind;
    logic        last;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   mismatches;
    int   outstanding;
    int   send_idle_pct = 36;
    int   recv_idle_pct = 62;
    int   holds_asked = 0;
    int   items_sent = 0;

    base32_stream_encoder_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .message_length (message_length),
        .buffer_length  (buffer_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .character      (character),
        .kind           (kind),
        .last           (last)
    );

    b32e_stream_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .message_length (message_length),
        .buffer_length  (buffer_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .character      (character),
        .kind           (kind),
        .last           (last),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
    end

    task automatic send_item(input logic op_in, input logic [12:0] len,
                             input logic [13:0] blen, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= op_in;
        message_length <= len;
        buffer_length <= blen;
        data_byte <= b;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    // A negative slack makes the buffer too small, so no bytes follow the start.
    task automatic send_message(input int len, input int slack, input int cut);
        int need;
        int i;
        need = ((len + 4) / 5) * 8;
        send_item(b32e_pkg::OP_START, 13'(len), 14'(need + 1 + slack),
                  8'($urandom_range(0, 255)));
        items_sent++;
        if (slack >= 0)
        begin
            for (i = 0; i < len - cut; i++)
            begin
                send_item(b32e_pkg::OP_DATA, 13'($urandom_range(0, 8191)),
                          14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)));
                items_sent++;
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (holds_asked > holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if (in_taken || out_taken)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int goal;
        int pick;
        int len;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A byte with no open message, then the start items that are refused or
        // finish at once.
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hFF);
        send_item(b32e_pkg::OP_START, 13'd0, 14'd0, 8'h00);
        send_item(b32e_pkg::OP_START, 13'd0, 14'd1, 8'h00);
        send_item(b32e_pkg::OP_START, 13'd4097, 14'd8192, 8'h00);
        send_item(b32e_pkg::OP_START, 13'd8191, 14'd16383, 8'hFF);
        send_item(b32e_pkg::OP_START, 13'd4096, 14'd100, 8'h00);
        send_item(b32e_pkg::OP_START, 13'd5, 14'd8, 8'h00);
        // A full group that fits exactly, then three bytes in the last group.
        send_item(b32e_pkg::OP_START, 13'd5, 14'd9, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hFF);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h80);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h7F);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hA5);
        send_item(b32e_pkg::OP_START, 13'd3, 14'd9, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hFF);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h0F);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hF1);
        // An open message dropped by a new start, then messages of one and two bytes.
        send_item(b32e_pkg::OP_START, 13'd4, 14'd16383, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h12);
        send_item(b32e_pkg::OP_START, 13'd1, 14'd9, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd8191, 14'd16383, 8'hFF);
        send_item(b32e_pkg::OP_START, 13'd2, 14'd9, 8'h00);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'h55);
        send_item(b32e_pkg::OP_DATA, 13'd0, 14'd0, 8'hAA);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    holds_asked++;
                    send_message(40, 0, 0);
                end
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                len = $urandom_range(1, 12);
                if (pick < 72)
                    send_message(len, $urandom_range(0, 3), 0);
                else if (pick < 80)
                    send_message(len, -1 - int'($urandom_range(0, 1)), 0);
                else if (pick < 88)
                    send_message(len, $urandom_range(0, 3), $urandom_range(1, len));
                else if (pick < 94)
                begin
                    send_item(b32e_pkg::OP_START, 13'($urandom_range(0, 8191)),
                              14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)));
                    items_sent++;
                end
                else
                begin
                    send_item(b32e_pkg::OP_DATA, 13'($urandom_range(0, 8191)),
                              14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)));
                    items_sent++;
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/b32e_pkg.sv
hdl/b32e_core.sv
hdl/b32e_emit.sv
hdl/base32_stream_encoder_top.sv
bench/b32e_stream_checker.sv
bench/base32_stream_encoder_top_tb.sv
